// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tod_pkg.sv =====
// Types, command codes and constants of the 24-hour time-of-day clock.
// Used by every module of the block and by its checker.
package tod_pkg;

	typedef enum logic [2:0] {
		CMD_LOAD_HMS   = 3'd0,
		CMD_LOAD_TOTAL = 3'd1,
		CMD_SET_HOUR   = 3'd2,
		CMD_SET_MINUTE = 3'd3,
		CMD_SET_SECOND = 3'd4,
		CMD_INC        = 3'd5,
		CMD_DEC        = 3'd6,
		CMD_ADD        = 3'd7
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [4:0]         hour_in;
		logic [5:0]         minute_in;
		logic [5:0]         second_in;
		logic signed [31:0] amount;
	} op_t;

	typedef struct packed {
		logic [4:0] hour_out;
		logic [5:0] minute_out;
		logic [5:0] second_out;
	} tod_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} hms_t;

	localparam logic [4:0] MAX_HOUR      = 5'd23;
	localparam logic [5:0] MAX_MIN       = 6'd59;
	localparam logic [5:0] MAX_SEC       = 6'd59;
	localparam logic [5:0] HOURS_PER_DAY = 6'd24;
	localparam logic [6:0] SECS_PER_MIN  = 7'd60;

	// 86400 = 128 * 675; 2^31 mod 86400 = 11648.
	localparam logic [16:0] SIGN_OFS_MOD  = 17'd11648;
	localparam logic [16:0] SIGN_OFS_COMP = 17'd74752;
	localparam logic [9:0]  DAY_ODD       = 10'd675;

	// Reciprocals: floor(x * RECIP >> SH) equals floor(x / divisor) over the operand range.
	localparam logic [25:0] RECIP_675   = 26'd50903317;
	localparam int          RECIP_675_SH = 35;
	localparam logic [18:0] RECIP_60_W  = 19'd279621;
	localparam int          RECIP_60_W_SH = 24;
	localparam logic [12:0] RECIP_60_N  = 13'd4370;
	localparam int          RECIP_60_N_SH = 18;

endpackage

// ===== src/time_of_day_clock_24h.sv =====
// Top level of the 24-hour time-of-day clock: amount reduction pipeline,
// time registers and result register. Depends on tod_pkg and tod_exec.
//
// The block keeps a time of day (hour, minute, second) and takes one command
// word per clock cycle on the op channel while op_stall is low; every command
// returns one word on the tod channel with the time after that command. A
// full rate of one word per cycle is sustained while tod_stall is low. Four
// stages ahead of the time registers reduce the signed 32-bit amount to
// floor-modulo one day and split it into hours, minutes and seconds using
// reciprocal multiplies; they never look at the time itself. The last stage
// adds that split amount to the time digit by digit (one carry chain through
// seconds, minutes and hours), so each word sees the time left by the word
// before it. Each stage advances whenever the stage after it is empty or
// moving, so bubbles collapse and new words are still taken while a finished
// result waits under tod_stall; op_stall rises only when every stage is full
// and the result is stalled.
module time_of_day_clock_24h import tod_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_stall,
	input  op_t  op,
	output logic tod_valid,
	input  logic tod_stall,
	output tod_t tod
);

	// Command fields carried alongside the amount reduction.
	typedef struct packed {
		cmd_t       cmd;
		logic [4:0] hour_in;
		logic [5:0] minute_in;
		logic [5:0] second_in;
		logic       amt_neg;
	} ctl_t;

	// Stage valids and load enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_out;

	// Stage 1: input word.
	op_t         op_s1;
	logic [31:0] ofs_amt;
	logic [50:0] prod675;
	ctl_t        ctl_s1;

	// Stage 2: quotient by 675 of the upper amount bits.
	ctl_t        ctl_s2;
	logic [24:0] hi_s2;
	logic [6:0]  lo_s2;
	logic [15:0] q675_s2;
	logic [25:0] back675;
	logic [24:0] rem675;
	logic [16:0] ofs_mod;
	logic [16:0] day_mod;

	// Stage 3: amount modulo one day.
	ctl_t        ctl_s3;
	logic [16:0] day_s3;
	logic [35:0] prod_mt;

	// Stage 4: total minutes.
	ctl_t        ctl_s4;
	logic [16:0] day_s4;
	logic [10:0] mt_s4;
	logic [16:0] mt_back;
	logic [23:0] prod_h;

	// Stage 5: hours, total minutes, seconds.
	ctl_t        ctl_s5;
	logic [4:0]  hr_s5;
	logic [10:0] mt_s5;
	logic [5:0]  sec_s5;
	logic [10:0] hr_back;
	hms_t        amt_hms;

	// Time registers and result.
	hms_t        time_q;
	hms_t        time_nxt;
	logic        tod_valid_q;
	tod_t        tod_q;

	// Advance a stage when the one after it is empty or moving.
	assign ld_out = !tod_valid_q || !tod_stall;
	assign ld_s5  = !v_s5 || ld_out;
	assign ld_s4  = !v_s4 || ld_s5;
	assign ld_s3  = !v_s3 || ld_s4;
	assign ld_s2  = !v_s2 || ld_s3;
	assign ld_s1  = !v_s1 || ld_s2;
	assign op_stall = !ld_s1;

	// Stage 1: bias the amount to unsigned and take the upper 25 bits by 675.
	// 86400 = 128 * 675, so the low 7 bits pass through the modulo untouched.
	assign ofs_amt = {~op_s1.amount[31], op_s1.amount[30:0]};
	assign prod675 = 51'(ofs_amt[31:7]) * 51'(RECIP_675);
	assign ctl_s1  = '{cmd: op_s1.cmd, hour_in: op_s1.hour_in, minute_in: op_s1.minute_in,
		second_in: op_s1.second_in, amt_neg: op_s1.amount[31]};

	// Stage 2: remainder by 675, then undo the 2^31 bias modulo one day.
	assign back675 = 26'(q675_s2) * 26'(DAY_ODD);
	assign rem675  = hi_s2 - back675[24:0];
	assign ofs_mod = {rem675[9:0], lo_s2};
	assign day_mod = (ofs_mod >= SIGN_OFS_MOD) ? (ofs_mod - SIGN_OFS_MOD)
		: (ofs_mod + SIGN_OFS_COMP);

	// Stage 3: total minutes of the reduced amount.
	assign prod_mt = 36'(day_s3) * 36'(RECIP_60_W);

	// Stage 4: seconds digit and hours of the reduced amount.
	assign mt_back = 17'(mt_s4) * 17'(SECS_PER_MIN);
	assign prod_h  = 24'(mt_s4) * 24'(RECIP_60_N);

	// Stage 5: minutes digit, then apply the command to the time.
	assign hr_back = 11'(hr_s5) * 11'(SECS_PER_MIN);
	assign amt_hms = '{hour: hr_s5, minute: 6'(mt_s5 - hr_back), second: sec_s5};

	tod_exec u_exec (
		.cmd       (ctl_s5.cmd),
		.hour_in   (ctl_s5.hour_in),
		.minute_in (ctl_s5.minute_in),
		.second_in (ctl_s5.second_in),
		.amt_neg   (ctl_s5.amt_neg),
		.amt_hms   (amt_hms),
		.cur       (time_q),
		.nxt       (time_nxt)
	);

	// Control: stage valids, time, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			tod_valid_q <= 1'b0;
			time_q      <= '0;
		end else begin
			if (ld_s1)
				v_s1 <= op_valid;
			if (ld_s2)
				v_s2 <= v_s1;
			if (ld_s3)
				v_s3 <= v_s2;
			if (ld_s4)
				v_s4 <= v_s3;
			if (ld_s5)
				v_s5 <= v_s4;
			if (ld_out) begin
				tod_valid_q <= v_s5;
				if (v_s5)
					time_q <= time_nxt;
			end
		end
	end

	// Payload: hold while stalled.
	always_ff @(posedge clk) begin
		if (ld_s1)
			op_s1 <= op;
		if (ld_s2) begin
			ctl_s2  <= ctl_s1;
			hi_s2   <= ofs_amt[31:7];
			lo_s2   <= ofs_amt[6:0];
			q675_s2 <= prod675[RECIP_675_SH +: 16];
		end
		if (ld_s3) begin
			ctl_s3 <= ctl_s2;
			day_s3 <= day_mod;
		end
		if (ld_s4) begin
			ctl_s4 <= ctl_s3;
			day_s4 <= day_s3;
			mt_s4  <= prod_mt[RECIP_60_W_SH +: 11];
		end
		if (ld_s5) begin
			ctl_s5 <= ctl_s4;
			hr_s5  <= prod_h[RECIP_60_N_SH +: 5];
			mt_s5  <= mt_s4;
			sec_s5 <= 6'(day_s4 - mt_back);
		end
		if (ld_out && v_s5)
			tod_q <= '{hour_out: time_nxt.hour, minute_out: time_nxt.minute,
				second_out: time_nxt.second};
	end

	assign tod_valid = tod_valid_q;
	assign tod       = tod_q;

endmodule

// ===== src/tod_exec.sv =====
// Execute step of the time-of-day clock: applies one command to the current time.
// Depends on tod_pkg.
module tod_exec import tod_pkg::*; (
	input  cmd_t       cmd,
	input  logic [4:0] hour_in,
	input  logic [5:0] minute_in,
	input  logic [5:0] second_in,
	input  logic       amt_neg,
	input  hms_t       amt_hms,
	input  hms_t       cur,
	output hms_t       nxt
);

	hms_t       delta;
	hms_t       sum;
	logic [6:0] s_sum;
	logic [6:0] m_sum;
	logic [5:0] h_sum;
	logic       c_s;
	logic       c_m;

	always_comb begin
		case (cmd)
			CMD_INC: delta = '{hour: 5'd0, minute: 6'd0, second: 6'd1};
			CMD_DEC: delta = '{hour: MAX_HOUR, minute: MAX_MIN, second: MAX_SEC};
			default: delta = amt_hms;
		endcase
	end

	// Mixed-radix add; both operands are below one day, so wrap at most once.
	always_comb begin
		s_sum = 7'(cur.second) + 7'(delta.second);
		c_s   = (s_sum >= SECS_PER_MIN);
		sum.second = c_s ? 6'(s_sum - SECS_PER_MIN) : s_sum[5:0];
		m_sum = 7'(cur.minute) + 7'(delta.minute) + 7'(c_s);
		c_m   = (m_sum >= SECS_PER_MIN);
		sum.minute = c_m ? 6'(m_sum - SECS_PER_MIN) : m_sum[5:0];
		h_sum = 6'(cur.hour) + 6'(delta.hour) + 6'(c_m);
		sum.hour = (h_sum >= HOURS_PER_DAY) ? 5'(h_sum - HOURS_PER_DAY) : h_sum[4:0];
	end

	always_comb begin
		nxt = cur;
		case (cmd)
			CMD_LOAD_HMS: begin
				if (hour_in > MAX_HOUR || minute_in > MAX_MIN || second_in > MAX_SEC)
					nxt = '0;
				else
					nxt = '{hour: hour_in, minute: minute_in, second: second_in};
			end
			CMD_LOAD_TOTAL: begin
				nxt = amt_neg ? hms_t'('0) : amt_hms;
			end
			CMD_SET_HOUR: begin
				if (hour_in <= MAX_HOUR)
					nxt.hour = hour_in;
			end
			CMD_SET_MINUTE: begin
				if (minute_in <= MAX_MIN)
					nxt.minute = minute_in;
			end
			CMD_SET_SECOND: begin
				if (second_in <= MAX_SEC)
					nxt.second = second_in;
			end
			CMD_INC, CMD_DEC, CMD_ADD: begin
				nxt = sum;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== src/tod_checker.sv =====
// Port-level checker for the time-of-day clock, bound to the top level.
// Depends on tod_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tod_checker import tod_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic op_valid,
	input logic op_stall,
	input op_t  op,
	input logic tod_valid,
	input logic tod_stall,
	input tod_t tod
);

	`ASSERT_NEXT(a_in_word_hold, clk, arst_n, op_valid && op_stall, op_valid && $stable(op), "command word changed while stalled")
	`ASSERT_NEXT(a_out_valid_hold, clk, arst_n, tod_valid && tod_stall, tod_valid, "result word dropped while stalled")
	`ASSERT_NEXT(a_out_word_hold, clk, arst_n, tod_valid && tod_stall, $stable(tod), "result word changed while stalled")
	`ASSERT_SAME(a_time_range, clk, arst_n, tod_valid, tod.hour_out <= MAX_HOUR && tod.minute_out <= MAX_MIN && tod.second_out <= MAX_SEC, "time out of range")
	`ASSERT_SAME(a_stall_cause, clk, arst_n, op_stall, tod_valid && tod_stall, "input stalled without output backpressure")

endmodule

bind time_of_day_clock_24h tod_checker u_tod_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.op_valid  (op_valid),
	.op_stall  (op_stall),
	.op        (op),
	.tod_valid (tod_valid),
	.tod_stall (tod_stall),
	.tod       (tod)
);

// ===== tb/sv/time_of_day_clock_24h_tb.sv =====
// Self-checking bench for the 24-hour time-of-day clock: predicts the time after each command
// word, compares every returned time word, and randomizes idling on both channels.
// Depends on tod_pkg and time_of_day_clock_24h.
module time_of_day_clock_24h_tb;
	import tod_pkg::*;

	localparam longint DAY_SECS  = 86400;
	localparam longint HOUR_SECS = 3600;
	localparam longint MIN_SECS  = 60;
	localparam int     HOLD_CYCLES = 40;
	localparam int     TAIL_CYCLES = 12;
	localparam int     TIMEOUT = 2000000;

	// Track the time of day, predict the time word for each accepted command word,
	// and check returned time words in order.
	class tod_scoreboard;
		logic [4:0] hr;
		logic [5:0] mn;
		logic [5:0] sc;
		tod_t due_times[$];
		int errors;
		int words_in;
		int words_out;
		int cmd_seen[8];
		int ignored_sets;
		int clearing_loads;
		int day_wraps;

		function new();
			hr = '0;
			mn = '0;
			sc = '0;
		endfunction

		function void clear_time();
			hr = '0;
			mn = '0;
			sc = '0;
		endfunction

		// Reduce a signed total with floor modulo one day and split it.
		function void set_total(longint t);
			longint r;
			r = t % DAY_SECS;
			if (r < 0)
				r += DAY_SECS;
			hr = 5'(r / HOUR_SECS);
			r -= longint'(hr) * HOUR_SECS;
			mn = 6'(r / MIN_SECS);
			sc = 6'(r - longint'(mn) * MIN_SECS);
		endfunction

		function void move_by(longint delta);
			longint t;
			t = longint'(hr) * HOUR_SECS + longint'(mn) * MIN_SECS + longint'(sc) + delta;
			if (t < 0 || t >= DAY_SECS)
				day_wraps++;
			set_total(t);
		endfunction

		function void apply_word(op_t w);
			longint amt;
			tod_t e;
			amt = longint'($signed(w.amount));
			words_in++;
			cmd_seen[w.cmd]++;
			case (w.cmd)
				CMD_LOAD_HMS: begin
					if (w.hour_in > MAX_HOUR || w.minute_in > MAX_MIN || w.second_in > MAX_SEC) begin
						clear_time();
						clearing_loads++;
					end else begin
						hr = w.hour_in;
						mn = w.minute_in;
						sc = w.second_in;
					end
				end
				CMD_LOAD_TOTAL: begin
					if (amt < 0) begin
						clear_time();
						clearing_loads++;
					end else
						set_total(amt);
				end
				CMD_SET_HOUR: begin
					if (w.hour_in <= MAX_HOUR)
						hr = w.hour_in;
					else
						ignored_sets++;
				end
				CMD_SET_MINUTE: begin
					if (w.minute_in <= MAX_MIN)
						mn = w.minute_in;
					else
						ignored_sets++;
				end
				CMD_SET_SECOND: begin
					if (w.second_in <= MAX_SEC)
						sc = w.second_in;
					else
						ignored_sets++;
				end
				CMD_INC: move_by(1);
				CMD_DEC: move_by(-1);
				CMD_ADD: move_by(amt);
			endcase
			e.hour_out = hr;
			e.minute_out = mn;
			e.second_out = sc;
			due_times.push_back(e);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("ERROR at %0t: %s", $realtime, msg);
		endfunction

		function void check_time(tod_t got);
			tod_t e;
			words_out++;
			if (due_times.size() == 0) begin
				flag($sformatf("time word %0d:%0d:%0d with none due",
					got.hour_out, got.minute_out, got.second_out));
				return;
			end
			e = due_times.pop_front();
			if (got.hour_out !== e.hour_out || got.minute_out !== e.minute_out
					|| got.second_out !== e.second_out)
				flag($sformatf("time word %0d: expected %0d:%0d:%0d, got %0d:%0d:%0d",
					words_out, e.hour_out, e.minute_out, e.second_out,
					got.hour_out, got.minute_out, got.second_out));
		endfunction

		function int pending();
			return due_times.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic op_valid;
	logic op_stall;
	op_t  op;
	logic tod_valid;
	logic tod_stall;
	tod_t tod;

	tod_scoreboard sb = new();

	bit send_idle;
	bit recv_idle;
	bit hold_req;
	int in_stall_cycles;

	time_of_day_clock_24h uut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_stall(op_stall),
		.op(op),
		.tod_valid(tod_valid),
		.tod_stall(tod_stall),
		.tod(tod)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both channels at the rising edge: a word moves when valid is high
	// and stall is low. Note inputs into the predictor, check outputs against it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (op_valid && !op_stall)
				sb.apply_word(op);
			if (tod_valid && !tod_stall)
				sb.check_time(tod);
			if (op_valid && op_stall)
				in_stall_cycles++;
		end
	end

	// Receiver: hold off for a long stretch on request, otherwise stall in
	// short random bursts while idling is enabled.
	initial begin
		tod_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				tod_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				tod_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (recv_idle && $urandom_range(0, 5) == 0) begin
				tod_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				tod_stall <= 1'b0;
			end
		end
	end

	// End the run if it hangs.
	initial begin
		#(TIMEOUT);
		$display("Timeout: %0d time words still due", sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic op_t make_word(cmd_t c, int h, int m, int s, logic [31:0] a);
		op_t w;
		w.cmd = c;
		w.hour_in = 5'(h);
		w.minute_in = 6'(m);
		w.second_in = 6'(s);
		w.amount = a;
		return w;
	endfunction

	// Random command word: mostly in-range fields, amounts spread over small
	// deltas, day boundaries, the full 32-bit range and its extremes.
	function automatic op_t rand_word();
		op_t w;
		int pick;
		int days;
		w.cmd = cmd_t'($urandom_range(0, 7));
		w.hour_in = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(24, 31))
			: 5'($urandom_range(0, 23));
		w.minute_in = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(60, 63))
			: 6'($urandom_range(0, 59));
		w.second_in = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(60, 63))
			: 6'($urandom_range(0, 59));
		pick = $urandom_range(0, 7);
		case (pick)
			0, 1: w.amount = $urandom();
			2, 3: w.amount = int'($urandom_range(0, 400000)) - 200000;
			4: begin
				days = $urandom_range(0, 24854);
				w.amount = days * 86400 + int'($urandom_range(0, 4)) - 2;
				if ($urandom_range(0, 1))
					w.amount = -w.amount;
			end
			5: w.amount = $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
				: 32'h80000000 + $urandom_range(0, 3);
			default: w.amount = int'($urandom_range(0, 6)) - 3;
		endcase
		return w;
	endfunction

	// Offer one word, hold it until taken, then maybe go idle for a burst.
	task automatic send_word(input op_t w);
		op <= w;
		op_valid <= 1'b1;
		@(posedge clk);
		while (op_stall)
			@(posedge clk);
		if (send_idle && $urandom_range(0, 4) == 0) begin
			op_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every predicted time word has come back.
	task automatic drain();
		op_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		op_valid <= 1'b0;
		op <= '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		hold_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every command, clearing loads, ignored sets,
		// wraps in both directions and the 32-bit amount extremes.
		send_word(make_word(CMD_LOAD_HMS, 23, 59, 59, 0));
		send_word(make_word(CMD_INC, 0, 0, 0, 0));
		send_word(make_word(CMD_DEC, 0, 0, 0, 0));
		send_word(make_word(CMD_LOAD_HMS, 24, 0, 0, 0));
		send_word(make_word(CMD_LOAD_HMS, 0, 60, 0, 0));
		send_word(make_word(CMD_LOAD_HMS, 0, 0, 60, 0));
		send_word(make_word(CMD_LOAD_HMS, 31, 63, 63, 32'hFFFFFFFF));
		send_word(make_word(CMD_DEC, 31, 63, 63, 32'h12345678));
		send_word(make_word(CMD_SET_HOUR, 0, 0, 0, 0));
		send_word(make_word(CMD_SET_HOUR, 24, 0, 0, 0));
		send_word(make_word(CMD_SET_MINUTE, 0, 0, 0, 0));
		send_word(make_word(CMD_SET_MINUTE, 0, 63, 0, 0));
		send_word(make_word(CMD_SET_SECOND, 0, 0, 59, 0));
		send_word(make_word(CMD_SET_SECOND, 0, 0, 60, 0));
		send_word(make_word(CMD_LOAD_TOTAL, 0, 0, 0, 86399));
		send_word(make_word(CMD_LOAD_TOTAL, 0, 0, 0, 86400));
		send_word(make_word(CMD_LOAD_TOTAL, 0, 0, 0, 32'hFFFFFFFF));
		send_word(make_word(CMD_LOAD_TOTAL, 0, 0, 0, 32'h7FFFFFFF));
		send_word(make_word(CMD_ADD, 0, 0, 0, 32'h7FFFFFFF));
		send_word(make_word(CMD_ADD, 0, 0, 0, 32'h80000000));
		send_word(make_word(CMD_ADD, 0, 0, 0, 32'hFFFFFFFF));
		send_word(make_word(CMD_LOAD_TOTAL, 0, 0, 0, 32'h80000000));
		send_word(make_word(CMD_ADD, 0, 0, 0, -86401));
		send_word(make_word(CMD_LOAD_TOTAL, 31, 63, 63, 0));
		send_word(make_word(CMD_SET_HOUR, 23, 63, 63, 32'hFFFFFFFF));
		drain();

		// Back-pressure: hold the receiver off while words keep coming, so the
		// pipeline fills and op_stall rises.
		hold_req = 1'b1;
		send_idle = 1'b0;
		for (int i = 0; i < 24; i++)
			send_word(rand_word());
		drain();

		// Random traffic; re-pick idling on both sides every fifty words so
		// that busy stretches and gappy stretches alternate.
		for (int i = 0; i < 340; i++) begin
			if (i % 50 == 0) begin
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
			end
			send_word(rand_word());
		end
		drain();

		// Final stretch at full rate, no idling anywhere.
		send_idle = 1'b0;
		recv_idle = 1'b0;
		for (int i = 0; i < 70; i++)
			send_word(rand_word());
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d command words and %0d time words (%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d per command).",
			sb.words_in, sb.words_out, sb.cmd_seen[0], sb.cmd_seen[1], sb.cmd_seen[2],
			sb.cmd_seen[3], sb.cmd_seen[4], sb.cmd_seen[5], sb.cmd_seen[6], sb.cmd_seen[7]);
		$display("Seen %0d ignored sets, %0d clearing loads, %0d day wraps, %0d input stall cycles.",
			sb.ignored_sets, sb.clearing_loads, sb.day_wraps, in_stall_cycles);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d time words still due", sb.errors, sb.pending());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/tod_pkg.sv
src/tod_exec.sv
src/time_of_day_clock_24h.sv
src/tod_checker.sv
tb/sv/time_of_day_clock_24h_tb.sv
